FILE: sv/gdn_pkg.sv
// Shared types, constants and small tables for the Gregorian day number converter.
// No dependencies; every other file refers to this package by scoped names.
package gdn_pkg;

  localparam logic REQ_TO_NUMBER = 1'b0;
  localparam logic REQ_TO_DATE   = 1'b1;

  localparam logic [13:0] YEAR_LIMIT    = 14'd9999;
  localparam logic [3:0]  MONTHS        = 4'd12;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // year estimate: floor((dn*10000+14780)/3652425) from below, exact after a step up
  localparam logic [23:0] YR_REC_MUL   = 24'd11759221;
  localparam int          YR_REC_SHIFT = 32;
  localparam logic [21:0] YR_DIV       = 22'd3652425;
  localparam logic [13:0] YR_SCALE     = 14'd10000;
  localparam logic [13:0] YR_OFFSET    = 14'd14780;

  // y / 100 for y < 16384
  localparam logic [12:0] C100_MUL   = 13'd5243;
  localparam int          C100_SHIFT = 19;

  // (100 * ddd + 52) / 3060 for ddd < 1024
  localparam logic [12:0] MI_MUL   = 13'd5483;
  localparam int          MI_SHIFT = 24;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [21:0] in_day_number;
  } gdn_req_t;

  typedef struct packed {
    logic [21:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic        is_leap;
  } gdn_rsp_t;

  // after year estimate / date clamp
  typedef struct packed {
    logic        req_type;
    logic [21:0] day_number;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [3:0]  m;
    logic [13:0] y;
  } gdn_yr_t;

  // after day-of-year split
  typedef struct packed {
    logic        req_type;
    logic [21:0] day_number;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] y;
    logic [9:0]  ddd;
  } gdn_dd_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                         len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

  // (306 * m + 5) / 10, days from March 1 to the start of March-based month m
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] ofs;
    unique case (m)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

FILE: sv/gdn_front.sv
// Front stages: date clamp and March-based shift, or year estimate and its correction.
// Uses gdn_pkg.
module gdn_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  gdn_pkg::gdn_req_t src_word,
  output logic             dst_valid,
  input  logic             dst_stall,
  output gdn_pkg::gdn_yr_t dst_word
);

  logic        s1_valid, s2_valid, s1_adv, s2_adv;
  logic        s1_req;
  logic [21:0] s1_dn;
  logic [4:0]  s1_day;
  logic [3:0]  s1_month;
  logic [13:0] s1_year;
  logic [3:0]  s1_m;
  logic [13:0] s1_y;
  logic [35:0] s1_p;

  logic [13:0] year_c;
  logic [3:0]  month_c;
  logic [4:0]  len;
  logic [4:0]  day_c;
  logic [3:0]  m;
  logic [13:0] y_f;
  logic [45:0] prod_k;
  logic [35:0] p;
  logic [35:0] prod_c;
  logic [35:0] rem;
  logic [13:0] y2;

  assign s2_adv    = !s2_valid || !dst_stall;
  assign s1_adv    = !s1_valid || s2_adv;
  assign src_stall = !s1_adv;
  assign dst_valid = s2_valid;

  always_comb begin
    year_c = src_word.in_year;
    if (src_word.in_year == 14'd0 || src_word.in_year >= gdn_pkg::YEAR_LIMIT) begin
      year_c = 14'd1;
    end
    month_c = src_word.in_month;
    if (src_word.in_month == 4'd0 || src_word.in_month > gdn_pkg::MONTHS) begin
      month_c = 4'd1;
    end
    len   = gdn_pkg::month_len(month_c, year_c[1:0] == 2'b00);
    day_c = src_word.in_day;
    if (src_word.in_day == 5'd0 || src_word.in_day > len) begin
      day_c = 5'd1;
    end
    if (month_c >= 4'd3) begin
      m = month_c - 4'd3;
    end else begin
      m = month_c + 4'd9;
    end
    y_f = year_c - {13'd0, m >= 4'd10};
  end

  assign prod_k = 46'(src_word.in_day_number) * 46'(gdn_pkg::YR_REC_MUL);
  assign p      = 36'(src_word.in_day_number) * 36'(gdn_pkg::YR_SCALE)
                + 36'(gdn_pkg::YR_OFFSET);

  // estimate is never above the true quotient, at most one below
  assign prod_c = 36'(s1_y) * 36'(gdn_pkg::YR_DIV);
  assign rem    = s1_p - prod_c;

  always_comb begin
    y2 = s1_y;
    if (s1_req == gdn_pkg::REQ_TO_DATE && rem >= 36'(gdn_pkg::YR_DIV)) begin
      y2 = s1_y + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= src_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_req   <= src_word.req_type;
      s1_dn    <= src_word.in_day_number;
      s1_day   <= day_c;
      s1_month <= month_c;
      s1_year  <= year_c;
      s1_m     <= m;
      s1_p     <= p;
      if (src_word.req_type == gdn_pkg::REQ_TO_DATE) begin
        s1_y <= prod_k[gdn_pkg::YR_REC_SHIFT +: 14];
      end else begin
        s1_y <= y_f;
      end
    end
    if (s2_adv) begin
      dst_word.req_type   <= s1_req;
      dst_word.day_number <= s1_dn;
      dst_word.day        <= s1_day;
      dst_word.month      <= s1_month;
      dst_word.year       <= s1_year;
      dst_word.m          <= s1_m;
      dst_word.y          <= y2;
    end
  end

endmodule

FILE: sv/gdn_year.sv
// Middle stages: days before the year, then the day number or the day of year.
// Uses gdn_pkg.
module gdn_year (
  input  logic             clk,
  input  logic             rst,
  input  logic             src_valid,
  output logic             src_stall,
  input  gdn_pkg::gdn_yr_t src_word,
  output logic             dst_valid,
  input  logic             dst_stall,
  output gdn_pkg::gdn_dd_t dst_word
);

  logic        s3_valid, s4_valid, s5_valid;
  logic        s3_adv, s4_adv, s5_adv;
  gdn_pkg::gdn_yr_t s3_word, s4_word;
  logic [22:0] s3_y365;
  logic [7:0]  s3_c100;
  logic [22:0] s4_dby;
  logic [22:0] s4_dby_prev;

  logic [22:0] y365;
  logic [26:0] c_prod;
  logic [22:0] dby;
  logic [13:0] c_back;
  logic        leap4, cent, q400;
  logic [8:0]  ylen;
  logic [21:0] dn_f;
  logic [23:0] diff;
  logic [23:0] diff_prev;
  logic [21:0] dn5;
  logic [13:0] y5;
  logic [9:0]  ddd5;

  assign s5_adv    = !s5_valid || !dst_stall;
  assign s4_adv    = !s4_valid || s5_adv;
  assign s3_adv    = !s3_valid || s4_adv;
  assign src_stall = !s3_adv;
  assign dst_valid = s5_valid;

  assign y365   = 23'(src_word.y) * 23'(gdn_pkg::DAYS_PER_YEAR);
  assign c_prod = 27'(src_word.y) * 27'(gdn_pkg::C100_MUL);

  always_comb begin
    dby    = s3_y365 + 23'(s3_word.y[13:2]) - 23'(s3_c100) + 23'(s3_c100[7:2]);
    c_back = 14'(s3_c100) * 14'd100;
    leap4  = s3_word.y[1:0] == 2'b00;
    cent   = c_back == s3_word.y;
    q400   = cent && s3_c100[1:0] == 2'b00;
    ylen   = gdn_pkg::DAYS_PER_YEAR + 9'(leap4) - 9'(cent) + 9'(q400);
  end

  always_comb begin
    dn_f      = 22'(s4_dby + 23'(gdn_pkg::month_offset(s4_word.m))
                + 23'(s4_word.day) - 23'd1);
    diff      = {2'b00, s4_word.day_number} - {1'b0, s4_dby};
    diff_prev = {2'b00, s4_word.day_number} - {1'b0, s4_dby_prev};
    if (s4_word.req_type == gdn_pkg::REQ_TO_DATE) begin
      dn5 = s4_word.day_number;
      if (diff[23]) begin
        y5   = s4_word.y - 14'd1;
        ddd5 = diff_prev[9:0];
      end else begin
        y5   = s4_word.y;
        ddd5 = diff[9:0];
      end
    end else begin
      dn5  = dn_f;
      y5   = s4_word.year;
      ddd5 = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s3_adv) begin
        s3_valid <= src_valid;
      end
      if (s4_adv) begin
        s4_valid <= s3_valid;
      end
      if (s5_adv) begin
        s5_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_word <= src_word;
      s3_y365 <= y365;
      s3_c100 <= c_prod[gdn_pkg::C100_SHIFT +: 8];
    end
    if (s4_adv) begin
      s4_word     <= s3_word;
      s4_dby      <= dby;
      s4_dby_prev <= dby - 23'(ylen);
    end
    if (s5_adv) begin
      dst_word.req_type   <= s4_word.req_type;
      dst_word.day_number <= dn5;
      dst_word.day        <= s4_word.day;
      dst_word.month      <= s4_word.month;
      dst_word.y          <= y5;
      dst_word.ddd        <= ddd5;
    end
  end

endmodule

FILE: sv/gdn_date.sv
// Back stages: month index from day of year, then day, month, year and leap flag.
// Uses gdn_pkg.
module gdn_date (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  gdn_pkg::gdn_dd_t  src_word,
  output logic              dst_valid,
  input  logic              dst_stall,
  output gdn_pkg::gdn_rsp_t dst_word
);

  logic        s6_valid, s7_valid, s6_adv, s7_adv;
  gdn_pkg::gdn_dd_t s6_word;
  logic [3:0]  s6_mi;

  logic [16:0] x;
  logic [29:0] mi_prod;
  logic [21:0] dn7;
  logic [4:0]  d7;
  logic [3:0]  mo7;
  logic [13:0] yr7;

  assign s7_adv    = !s7_valid || !dst_stall;
  assign s6_adv    = !s6_valid || s7_adv;
  assign src_stall = !s6_adv;
  assign dst_valid = s7_valid;

  assign x       = 17'(src_word.ddd) * 17'd100 + 17'd52;
  assign mi_prod = 30'(x) * 30'(gdn_pkg::MI_MUL);

  always_comb begin
    dn7 = s6_word.day_number;
    if (s6_word.req_type == gdn_pkg::REQ_TO_DATE) begin
      d7 = 5'(s6_word.ddd - 10'(gdn_pkg::month_offset(s6_mi)) + 10'd1);
      if (s6_mi >= 4'd10) begin
        mo7 = s6_mi - 4'd9;
        yr7 = s6_word.y + 14'd1;
      end else begin
        mo7 = s6_mi + 4'd3;
        yr7 = s6_word.y;
      end
    end else begin
      d7  = s6_word.day;
      mo7 = s6_word.month;
      yr7 = s6_word.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
    end else begin
      if (s6_adv) begin
        s6_valid <= src_valid;
      end
      if (s7_adv) begin
        s7_valid <= s6_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s6_adv) begin
      s6_word <= src_word;
      s6_mi   <= mi_prod[gdn_pkg::MI_SHIFT +: 4];
    end
    if (s7_adv) begin
      dst_word.out_day_number <= dn7;
      dst_word.out_day        <= d7;
      dst_word.out_month      <= mo7;
      dst_word.out_year       <= yr7;
      dst_word.is_leap        <= yr7[1:0] == 2'b00;
    end
  end

endmodule

FILE: sv/gregorian_day_number_converter.sv
// Gregorian date <-> running day number converter, top level.
// Chains gdn_front, gdn_year and gdn_date; uses gdn_pkg.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request word.
//   req.req_type selects the direction: date to day number, or day number
//   to date. Out-of-range year, month or day are clamped to 1 first.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one word per request,
//   in request order, with day number, day, month, year and leap flag.
// Timing:
//   Seven register stages; a word accepted on req passes through all of them
//   before it is offered on rsp.
//   One word per cycle is sustained while rsp is not stalled.
//   Each stage holds a valid bit and moves whenever the stage after it is
//   empty or moving, so bubbles close up and new words are taken while a
//   result waits on a stalled rsp until all seven stages are full.
//   rsp and every stage hold their contents while stalled.
// Reset:
//   Synchronous rst empties all stages; rsp_valid is low after reset.
module gregorian_day_number_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  gdn_pkg::gdn_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output gdn_pkg::gdn_rsp_t rsp
);

  logic             front_valid, front_stall;
  gdn_pkg::gdn_yr_t front_word;
  logic             year_valid, year_stall;
  gdn_pkg::gdn_dd_t year_word;

  gdn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (req_valid),
    .src_stall (req_stall),
    .src_word  (req),
    .dst_valid (front_valid),
    .dst_stall (front_stall),
    .dst_word  (front_word)
  );

  gdn_year u_year (
    .clk       (clk),
    .rst       (rst),
    .src_valid (front_valid),
    .src_stall (front_stall),
    .src_word  (front_word),
    .dst_valid (year_valid),
    .dst_stall (year_stall),
    .dst_word  (year_word)
  );

  gdn_date u_date (
    .clk       (clk),
    .rst       (rst),
    .src_valid (year_valid),
    .src_stall (year_stall),
    .src_word  (year_word),
    .dst_valid (rsp_valid),
    .dst_stall (rsp_stall),
    .dst_word  (rsp)
  );

endmodule

FILE: sv/gdn_checker.sv
// Port-level checks for gregorian_day_number_converter, attached by bind.
// Uses gdn_pkg.
module gdn_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input gdn_pkg::gdn_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid set after reset");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.out_month >= 4'd1 && rsp.out_month <= gdn_pkg::MONTHS)
    else $error("month out of range");

  a_leap_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.is_leap == (rsp.out_year[1:0] == 2'b00))
    else $error("leap flag disagrees with year");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |-> rsp_valid && rsp_stall)
    else $error("req stalled while rsp not stalled");

endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (.*);

FILE: tb/gregorian_day_number_converter_tb.sv
// Testbench for gregorian_day_number_converter: directed table, a held-receiver fill,
// then random words under several idle/stall mixes. Results are checked in order
// against typed values or date_convert. Depends on gdn_pkg and the converter RTL only.
`timescale 1ns / 100ps

module gregorian_day_number_converter_tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 16;
  localparam int PHASE_WORDS  = 450;
  localparam int PRESS_WORDS  = 40;
  localparam int N_DIRECTED   = 21;

  typedef struct {
    gdn_pkg::gdn_req_t w;
    bit                typed;
    gdn_pkg::gdn_rsp_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  gdn_pkg::gdn_req_t req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  gdn_pkg::gdn_rsp_t rsp;

  gdn_pkg::gdn_rsp_t pending_results[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       hold_req = 1'b0;

  // extremes, clamps and calendar corner cases; typed results are easy to read off
  stim_row_t directed [N_DIRECTED] = '{
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd1,  4'd1,  14'd1,     22'd0},       1'b1,
      '{22'd306, 5'd1, 4'd1, 14'd1, 1'b0}},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd0,  4'd0,  14'd0,     22'd0},       1'b1,
      '{22'd0, 5'd1, 4'd3, 14'd0, 1'b1}},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd31, 4'd15, 14'd16383, 22'h3FFFFF},  1'b1,
      '{22'd336, 5'd31, 4'd1, 14'd1, 1'b0}},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd31, 4'd15, 14'd16383, 22'd305},     1'b0, '0},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd0,  4'd0,  14'd0,     22'd306},     1'b0, '0},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd31, 4'd15, 14'd16383, 22'h3FFFFF},  1'b0, '0},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd7,  4'd9,  14'd2024,  22'd3652424}, 1'b0, '0},
    '{'{gdn_pkg::REQ_TO_DATE,   5'd0,  4'd0,  14'd0,     22'd730119},  1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd15, 4'd6,  14'd0,     22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd15, 4'd6,  14'd9999,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd31, 4'd12, 14'd9998,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd1,  4'd1,  14'd9998,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd5,  4'd0,  14'd2024,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd5,  4'd13, 14'd2024,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd0,  4'd7,  14'd1999,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd31, 4'd4,  14'd2023,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd29, 4'd2,  14'd2000,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd29, 4'd2,  14'd1900,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd29, 4'd2,  14'd2001,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd30, 4'd2,  14'd2004,  22'd0},       1'b0, '0},
    '{'{gdn_pkg::REQ_TO_NUMBER, 5'd31, 4'd1,  14'd2001,  22'h2AAAAA},  1'b0, '0}
  };

  gregorian_day_number_converter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint days_to_year(input longint y);
    return 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic gdn_pkg::gdn_rsp_t date_convert(input gdn_pkg::gdn_req_t w);
    longint            dn, d, mo, yr, m, y, ddd, mi, len;
    gdn_pkg::gdn_rsp_t o;
    if (w.req_type == gdn_pkg::REQ_TO_NUMBER) begin
      d  = longint'(w.in_day);
      mo = longint'(w.in_month);
      yr = longint'(w.in_year);
      if (yr == 0 || yr >= 9999) yr = 1;
      if (mo == 0 || mo > 12) mo = 1;
      case (mo)
        2:           len = (yr % 4 == 0) ? 29 : 28;
        4, 6, 9, 11: len = 30;
        default:     len = 31;
      endcase
      if (d == 0 || d > len) d = 1;
      m  = (mo + 9) % 12;
      y  = yr - m / 10;
      dn = days_to_year(y) + (m * 306 + 5) / 10 + d - 1;
    end else begin
      dn  = longint'(w.in_day_number);
      y   = (10000 * dn + 14780) / 3652425;
      ddd = dn - days_to_year(y);
      if (ddd < 0) begin
        y--;
        ddd = dn - days_to_year(y);
      end
      mi = (100 * ddd + 52) / 3060;
      mo = (mi + 2) % 12 + 1;
      yr = y + (mi + 2) / 12;
      d  = ddd - (mi * 306 + 5) / 10 + 1;
    end
    o.out_day_number = dn[21:0];
    o.out_day        = d[4:0];
    o.out_month      = mo[3:0];
    o.out_year       = yr[13:0];
    o.is_leap        = (yr[1:0] == 2'd0);
    return o;
  endfunction

  // mostly plausible dates and day numbers, some fully random words
  function automatic gdn_pkg::gdn_req_t random_word();
    gdn_pkg::gdn_req_t w;
    w = 46'({$urandom, $urandom});
    if ($urandom_range(9) >= 2) begin
      if (w.req_type == gdn_pkg::REQ_TO_NUMBER) begin
        case ($urandom_range(7))
          0:       w.in_year = 14'($urandom_range(4, 1));
          1:       w.in_year = 14'($urandom_range(9998, 9995));
          default: w.in_year = 14'($urandom_range(9998, 1));
        endcase
        w.in_month = 4'($urandom_range(12, 1));
        w.in_day   = 5'($urandom_range(31, 1));
      end else begin
        if ($urandom_range(3) == 0) w.in_day_number = 22'($urandom_range(800));
        else w.in_day_number = 22'($urandom_range(3652424));
      end
    end
    return w;
  endfunction

  task automatic send_word(input gdn_pkg::gdn_req_t w, input gdn_pkg::gdn_rsp_t want);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_results.push_back(want);
  endtask

  task automatic go_idle();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word(input gdn_pkg::gdn_rsp_t got);
    gdn_pkg::gdn_rsp_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected word, expected none got %p", $time, got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      if ($isunknown(got)) begin
        $display("%0t: word expected %p got %p", $time, want, got);
        mismatches++;
      end else begin
        check_field("out_day_number", longint'(want.out_day_number),
                    longint'(got.out_day_number));
        check_field("out_day", longint'(want.out_day), longint'(got.out_day));
        check_field("out_month", longint'(want.out_month), longint'(got.out_month));
        check_field("out_year", longint'(want.out_year), longint'(got.out_year));
        check_field("is_leap", longint'(want.is_leap), longint'(got.is_leap));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) check_word(rsp);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall, or one long hold when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    gdn_pkg::gdn_req_t w;
    idle_mix  = '{0, 60, 0, 9};
    stall_mix = '{0, 0, 60, 9};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(directed[i].w, directed[i].typed ? directed[i].want
                                                 : date_convert(directed[i].w));
    end
    go_idle();
    wait_for_results();

    // fill the pipe against a held-off receiver
    @(posedge clk);
    hold_req = 1'b1;
    repeat (PRESS_WORDS) begin
      w = random_word();
      send_word(w, date_convert(w));
    end
    go_idle();
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      repeat (PHASE_WORDS) begin
        w = random_word();
        send_word(w, date_convert(w));
      end
      go_idle();
      wait_for_results();
    end

    stall_pct = 0;
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gdn_pkg.sv
sv/gdn_front.sv
sv/gdn_year.sv
sv/gdn_date.sv
sv/gregorian_day_number_converter.sv
sv/gdn_checker.sv
tb/gregorian_day_number_converter_tb.sv
